// ----- rtl/drc_pkg.sv -----
// drc_pkg: shared types and constants for the dirty rectangle coalescer
// holds the beat structs, the stored box type and register indexes
// no dependencies
`timescale 1ns / 1ps

package drc_pkg;

  localparam int MAX_REGIONS   = 8;
  localparam int IDX_W         = $clog2(MAX_REGIONS);
  localparam int CNT_W         = $clog2(MAX_REGIONS + 1);
  localparam int COORD_W       = 15;
  localparam int EXPAND_MARGIN = 2;
  localparam int EXPAND_GROW   = 4;

  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 15'd320;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 15'd240;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_DEBUG_EXPAND  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FUNC_INVALIDATE = 1'b0,
    FUNC_DRAIN      = 1'b1
  } func_t;

  typedef struct packed {
    logic              func;
    logic signed [15:0] rect_left;
    logic signed [15:0] rect_top;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_left;
    logic [COORD_W-1:0] out_top;
    logic [COORD_W-1:0] out_width;
    logic [COORD_W-1:0] out_height;
    logic               entry_valid;
    logic [3:0]         entry_count;
    logic               last;
  } out_t;

  // one stored region, all edges within the screen
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } box_t;

endpackage

// ----- rtl/dirty_rect_coalescer.sv -----
// dirty_rect_coalescer: top level, microcoded sequencer over a region table
// depends on drc_pkg for beat structs, box type and constants
`timescale 1ns / 1ps

// Keeps up to eight screen regions that need redrawing. An invalidate beat
// (func 0) is expanded if debug_expand is set, clipped to the screen, then
// merged into the first touching entry (which absorbs any others it touches),
// appended, or collapsed with the whole table into one box when full; it
// returns one beat carrying the new entry count. A drain beat (func 1) returns
// one beat per stored entry in slot order, last set on the final one, or a
// single empty beat when the table holds nothing. Control comes from a small
// microcode table stepping a single-port region memory, one access per cycle,
// so timing follows the table walk. After acceptance an invalidate steps
// through expansion and clipping, a read and test per entry scanned up to and
// including the hit, a pass over the other entries in which each absorbed
// entry is refilled from the last one (or the merged entry moves into its
// slot when it is the last one), and a store and report. A rectangle that
// hits nothing is appended after a scan of every entry, and a full table is
// then folded into one box by a further pass over all entries. An empty
// rectangle goes straight to the report step, or after clipping when it clips
// to nothing. A drain reads and emits each entry in turn. in_ready returns
// the cycle after the last step, and the report and emit steps wait while the
// output register is still full. One beat is worked on at a time; a finished
// result sits in the output register while the next beat is accepted. There
// is no clearing pass after reset.
module dirty_rect_coalescer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  drc_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output drc_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [drc_pkg::COORD_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_EXP, S_CLIPL, S_CLIPR, S_CHK, S_ILOOP, S_ITEST, S_JLOOP,
    S_JSKIP, S_JTEST, S_JHIT, S_COPY, S_STORE, S_APPEND, S_CLOOP, S_CACC,
    S_CSTORE, S_REPORT, S_DRAIN, S_DREAD, S_DEMIT
  } step_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_EXPAND, OP_CLIP_LT, OP_CLIP_RB, OP_LOAD_NB, OP_READ_I,
    OP_TEST_I, OP_READ_J, OP_TEST_J, OP_ABSORB, OP_COPY_J, OP_STORE_I,
    OP_APPEND, OP_ACC, OP_STORE_ALL, OP_EMIT_CNT
  } op_t;

  typedef enum logic [1:0] {
    OPX_NONE, OPX_DRAIN_START, OPX_READ_K, OPX_EMIT_ENTRY
  } opx_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_R_EMPTY, C_I_GE_CNT, C_NO_TOUCH, C_J_GE_CNT, C_J_EQ_I,
    C_LAST_EQ_I, C_CNT_LT_MAX, C_CNT_ZERO, C_K_LAST
  } cond_t;

  typedef struct packed {
    op_t   op;
    opx_t  opx;
    cond_t cond;
    step_t jt;
    step_t jf;
    logic  wait_out;
  } uword_t;

  localparam int IW = drc_pkg::IDX_W;
  localparam int CW = drc_pkg::CNT_W;

  function automatic uword_t rom(input step_t s);
    uword_t w;
    begin
      unique case (s)
        S_IDLE:   w = '{OP_NOP,       OPX_NONE, C_ALWAYS,     S_IDLE,   S_IDLE,   1'b0};
        S_EXP:    w = '{OP_EXPAND,    OPX_NONE, C_R_EMPTY,    S_REPORT, S_CLIPL,  1'b0};
        S_CLIPL:  w = '{OP_CLIP_LT,   OPX_NONE, C_ALWAYS,     S_CLIPR,  S_CLIPR,  1'b0};
        S_CLIPR:  w = '{OP_CLIP_RB,   OPX_NONE, C_ALWAYS,     S_CHK,    S_CHK,    1'b0};
        S_CHK:    w = '{OP_LOAD_NB,   OPX_NONE, C_R_EMPTY,    S_REPORT, S_ILOOP,  1'b0};
        S_ILOOP:  w = '{OP_READ_I,    OPX_NONE, C_I_GE_CNT,   S_APPEND, S_ITEST,  1'b0};
        S_ITEST:  w = '{OP_TEST_I,    OPX_NONE, C_NO_TOUCH,   S_ILOOP,  S_JLOOP,  1'b0};
        S_JLOOP:  w = '{OP_NOP,       OPX_NONE, C_J_GE_CNT,   S_STORE,  S_JSKIP,  1'b0};
        S_JSKIP:  w = '{OP_READ_J,    OPX_NONE, C_J_EQ_I,     S_JLOOP,  S_JTEST,  1'b0};
        S_JTEST:  w = '{OP_TEST_J,    OPX_NONE, C_NO_TOUCH,   S_JLOOP,  S_JHIT,   1'b0};
        S_JHIT:   w = '{OP_ABSORB,    OPX_NONE, C_LAST_EQ_I,  S_JLOOP,  S_COPY,   1'b0};
        S_COPY:   w = '{OP_COPY_J,    OPX_NONE, C_ALWAYS,     S_JLOOP,  S_JLOOP,  1'b0};
        S_STORE:  w = '{OP_STORE_I,   OPX_NONE, C_ALWAYS,     S_REPORT, S_REPORT, 1'b0};
        S_APPEND: w = '{OP_APPEND,    OPX_NONE, C_CNT_LT_MAX, S_REPORT, S_CLOOP,  1'b0};
        S_CLOOP:  w = '{OP_READ_I,    OPX_NONE, C_I_GE_CNT,   S_CSTORE, S_CACC,   1'b0};
        S_CACC:   w = '{OP_ACC,       OPX_NONE, C_ALWAYS,     S_CLOOP,  S_CLOOP,  1'b0};
        S_CSTORE: w = '{OP_STORE_ALL, OPX_NONE, C_ALWAYS,     S_REPORT, S_REPORT, 1'b0};
        S_REPORT: w = '{OP_EMIT_CNT,  OPX_NONE, C_ALWAYS,     S_IDLE,   S_IDLE,   1'b1};
        S_DRAIN:  w = '{OP_NOP, OPX_DRAIN_START, C_CNT_ZERO,  S_REPORT, S_DREAD,  1'b0};
        S_DREAD:  w = '{OP_NOP, OPX_READ_K,     C_ALWAYS,     S_DEMIT,  S_DEMIT,  1'b0};
        S_DEMIT:  w = '{OP_NOP, OPX_EMIT_ENTRY, C_K_LAST,     S_IDLE,   S_DREAD,  1'b1};
        default:  w = '{OP_NOP,       OPX_NONE, C_ALWAYS,     S_IDLE,   S_IDLE,   1'b0};
      endcase
      return w;
    end
  endfunction

  // edges that meet count as touching
  function automatic logic touches(input drc_pkg::box_t a, input drc_pkg::box_t b);
    logic [15:0] ax2, ay2, bx2, by2;
    begin
      ax2 = {1'b0, a.x} + {1'b0, a.w};
      ay2 = {1'b0, a.y} + {1'b0, a.h};
      bx2 = {1'b0, b.x} + {1'b0, b.w};
      by2 = {1'b0, b.y} + {1'b0, b.h};
      return !(bx2 < {1'b0, a.x} || {1'b0, b.x} > ax2 ||
               by2 < {1'b0, a.y} || {1'b0, b.y} > ay2);
    end
  endfunction

  function automatic drc_pkg::box_t bound(input drc_pkg::box_t a, input drc_pkg::box_t b);
    logic [15:0] ax2, ay2, bx2, by2, x2, y2;
    drc_pkg::box_t r;
    begin
      ax2 = {1'b0, a.x} + {1'b0, a.w};
      ay2 = {1'b0, a.y} + {1'b0, a.h};
      bx2 = {1'b0, b.x} + {1'b0, b.w};
      by2 = {1'b0, b.y} + {1'b0, b.h};
      x2  = (ax2 > bx2) ? ax2 : bx2;
      y2  = (ay2 > by2) ? ay2 : by2;
      r.x = (a.x < b.x) ? a.x : b.x;
      r.y = (a.y < b.y) ? a.y : b.y;
      r.w = drc_pkg::COORD_W'(x2 - {1'b0, r.x});
      r.h = drc_pkg::COORD_W'(y2 - {1'b0, r.y});
      return r;
    end
  endfunction

  // configuration
  logic [drc_pkg::COORD_W-1:0] screen_width, screen_height;
  logic                        debug_expand;

  // sequencer and datapath
  step_t               step;
  logic [CW-1:0]       count, i, j, k, n;
  logic signed [17:0]  rx, ry, rw, rh;
  drc_pkg::box_t       nb, m, rd;
  drc_pkg::box_t       mem [drc_pkg::MAX_REGIONS];

  uword_t              uw;
  logic                stall, act, cond_true, touch, in_acc;
  logic [IW-1:0]       last_slot;
  logic signed [17:0]  sw_ext, sh_ext;
  drc_pkg::box_t       bnd_a, bnd;
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  drc_pkg::box_t       mem_wdata;

  assign in_ready  = (step == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign sw_ext    = $signed({3'b000, screen_width});
  assign sh_ext    = $signed({3'b000, screen_height});
  assign last_slot = IW'(count - CW'(1));

  always_comb begin
    uw    = rom(step);
    stall = uw.wait_out && out_valid && !out_ready;
    act   = !stall && (step != S_IDLE);
    // shared merge unit: the new box against a stored entry, or the running merge
    bnd_a = (uw.op == OP_TEST_I) ? nb : m;
    touch = touches(bnd_a, rd);
    bnd   = bound(bnd_a, rd);

    unique case (uw.cond)
      C_ALWAYS:     cond_true = 1'b1;
      C_R_EMPTY:    cond_true = (rw <= 18'sd0) || (rh <= 18'sd0);
      C_I_GE_CNT:   cond_true = (i >= count);
      C_NO_TOUCH:   cond_true = !touch;
      C_J_GE_CNT:   cond_true = (j >= count);
      C_J_EQ_I:     cond_true = (j == i);
      C_LAST_EQ_I:  cond_true = ({1'b0, last_slot} == i);
      C_CNT_LT_MAX: cond_true = (count < CW'(drc_pkg::MAX_REGIONS));
      C_CNT_ZERO:   cond_true = (count == '0);
      C_K_LAST:     cond_true = (k + CW'(1) == n);
      default:      cond_true = 1'b1;
    endcase

    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = m;
    if (act) begin
      unique case (uw.op)
        OP_READ_I: begin
          mem_re    = 1'b1;
          mem_raddr = i[IW-1:0];
        end
        OP_READ_J: begin
          mem_re    = 1'b1;
          mem_raddr = j[IW-1:0];
        end
        OP_ABSORB: begin
          // fetch the last entry to fill the absorbed slot
          mem_re    = 1'b1;
          mem_raddr = last_slot;
        end
        OP_COPY_J: begin
          mem_we    = 1'b1;
          mem_waddr = j[IW-1:0];
          mem_wdata = rd;
        end
        OP_STORE_I: begin
          mem_we    = 1'b1;
          mem_waddr = i[IW-1:0];
        end
        OP_APPEND: begin
          mem_we    = (count < CW'(drc_pkg::MAX_REGIONS));
          mem_waddr = count[IW-1:0];
          mem_wdata = nb;
        end
        OP_STORE_ALL: begin
          mem_we    = 1'b1;
          mem_waddr = '0;
        end
        default: begin
        end
      endcase
      if (uw.opx == OPX_READ_K) begin
        mem_re    = 1'b1;
        mem_raddr = k[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= S_IDLE;
      count         <= '0;
      out_valid     <= 1'b0;
      screen_width  <= drc_pkg::SCREEN_WIDTH_RST;
      screen_height <= drc_pkg::SCREEN_HEIGHT_RST;
      debug_expand  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          drc_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          drc_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
          drc_pkg::CFG_DEBUG_EXPAND:  debug_expand  <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (act && (uw.op == OP_EMIT_CNT || uw.opx == OPX_EMIT_ENTRY)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (in_acc) begin
        rx   <= 18'(in_data.rect_left);
        ry   <= 18'(in_data.rect_top);
        rw   <= 18'(in_data.rect_width);
        rh   <= 18'(in_data.rect_height);
        step <= (in_data.func == drc_pkg::FUNC_DRAIN) ? S_DRAIN : S_EXP;
      end else if (act) begin
        step <= cond_true ? uw.jt : uw.jf;
      end

      if (act) begin
        unique case (uw.op)
          OP_EXPAND: begin
            if (debug_expand) begin
              rx <= rx - 18'(drc_pkg::EXPAND_MARGIN);
              ry <= ry - 18'(drc_pkg::EXPAND_MARGIN);
              rw <= rw + 18'(drc_pkg::EXPAND_GROW);
              rh <= rh + 18'(drc_pkg::EXPAND_GROW);
            end
          end
          OP_CLIP_LT: begin
            if (rx < 18'sd0) begin
              rw <= rw + rx;
              rx <= '0;
            end
            if (ry < 18'sd0) begin
              rh <= rh + ry;
              ry <= '0;
            end
          end
          OP_CLIP_RB: begin
            if (rx + rw > sw_ext) rw <= sw_ext - rx;
            if (ry + rh > sh_ext) rh <= sh_ext - ry;
          end
          OP_LOAD_NB: begin
            nb.x <= rx[drc_pkg::COORD_W-1:0];
            nb.y <= ry[drc_pkg::COORD_W-1:0];
            nb.w <= rw[drc_pkg::COORD_W-1:0];
            nb.h <= rh[drc_pkg::COORD_W-1:0];
            i    <= '0;
          end
          OP_TEST_I: begin
            if (touch) begin
              m <= bnd;
              j <= '0;
            end else begin
              i <= i + CW'(1);
            end
          end
          OP_READ_J: begin
            if (j == i) j <= j + CW'(1);
          end
          OP_TEST_J: begin
            if (touch) m <= bnd;
            else       j <= j + CW'(1);
          end
          OP_ABSORB: begin
            count <= count - CW'(1);
            // merged entry is the last one: it moves into the absorbed slot
            if ({1'b0, last_slot} == i) i <= j;
          end
          OP_APPEND: begin
            if (count < CW'(drc_pkg::MAX_REGIONS)) begin
              count <= count + CW'(1);
            end else begin
              m <= nb;
              i <= '0;
            end
          end
          OP_ACC: begin
            m <= bnd;
            i <= i + CW'(1);
          end
          OP_STORE_ALL: count <= CW'(1);
          OP_EMIT_CNT: begin
            out_data <= '{'0, '0, '0, '0, 1'b0, 4'(count), 1'b1};
          end
          default: begin
          end
        endcase

        unique case (uw.opx)
          OPX_DRAIN_START: begin
            n     <= count;
            count <= '0;
            k     <= '0;
          end
          OPX_EMIT_ENTRY: begin
            out_data <= '{rd.x, rd.y, rd.w, rd.h, 1'b1, 4'd0, (k + CW'(1) == n)};
            k        <= k + CW'(1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // one beat in flight: an accepted beat holds off the next
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a beat was still in work");

  // table never holds more than its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(drc_pkg::MAX_REGIONS))
    else $error("region count beyond table depth");

  // a drained entry always reports an emptied table
  a_drain_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.entry_valid |-> out_data.entry_count == 4'd0)
    else $error("drained entry with non-zero count");

  // a result is only launched when the output register is free
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pending result overwritten");

endmodule

// ----- sim/tb_dirty_rect_coalescer.sv -----
// tb_dirty_rect_coalescer: self-checking bench for the dirty rectangle coalescer
// keeps its own region table model, drives command beats in bursts, checks result beats
// depends on rtl/drc_pkg.sv and rtl/dirty_rect_coalescer.sv
`timescale 1ns / 1ps

module tb_dirty_rect_coalescer;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } area_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  drc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  drc_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [drc_pkg::COORD_W-1:0] cfg_data = '0;

  dirty_rect_coalescer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model of the region table and its settings
  area_t regions[drc_pkg::MAX_REGIONS];
  int n_regions = 0;
  int scr_w = 320;
  int scr_h = 240;
  bit grow_cfg = 1'b0;

  drc_pkg::in_t rect_cmds_q[$];
  drc_pkg::out_t region_beats_q[$];

  int n_cmds = 0;
  int n_checked = 0;
  int n_drains = 0;
  int n_collapses = 0;
  int n_phases = 1;
  int bad_beats = 0;

  // idling knobs
  bit steady_send = 1'b0;
  bit steady_recv = 1'b0;
  int stall_period = 3;
  int stall_on = 2;
  int burst_left = 4;
  int gap_left = 0;
  int recv_cyc = 0;

  function automatic bit rects_touch(area_t a, area_t b);
    return !((b.x + b.w) < a.x || b.x > (a.x + a.w) || (b.y + b.h) < a.y || b.y > (a.y + a.h));
  endfunction

  function automatic area_t bbox(area_t a, area_t b);
    area_t r;
    int x2, y2;
    x2 = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
    y2 = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
    r.x = (a.x < b.x) ? a.x : b.x;
    r.y = (a.y < b.y) ? a.y : b.y;
    r.w = x2 - r.x;
    r.h = y2 - r.y;
    return r;
  endfunction

  function automatic void merge_rect(area_t r);
    area_t m;
    int i, j, last_slot;
    if (r.w <= 0 || r.h <= 0) return;
    if (grow_cfg) begin
      r.x -= drc_pkg::EXPAND_MARGIN;
      r.y -= drc_pkg::EXPAND_MARGIN;
      r.w += drc_pkg::EXPAND_GROW;
      r.h += drc_pkg::EXPAND_GROW;
    end
    if (r.x < 0) begin
      r.w += r.x;
      r.x = 0;
    end
    if (r.y < 0) begin
      r.h += r.y;
      r.y = 0;
    end
    if (r.w <= 0 || r.h <= 0) return;
    if (r.x + r.w > scr_w) r.w = scr_w - r.x;
    if (r.y + r.h > scr_h) r.h = scr_h - r.y;
    if (r.w <= 0 || r.h <= 0) return;

    i = 0;
    while (i < n_regions) begin
      if (rects_touch(regions[i], r)) begin
        m = bbox(regions[i], r);
        j = 0;
        while (j < n_regions) begin
          if (j == i) begin
            j++;
          end else if (rects_touch(m, regions[j])) begin
            last_slot = n_regions - 1;
            m = bbox(m, regions[j]);
            // the growing entry itself fills the hole, so follow it there
            if (last_slot == i) i = j;
            else regions[j] = regions[last_slot];
            n_regions--;
          end else begin
            j++;
          end
        end
        regions[i] = m;
        return;
      end
      i++;
    end

    if (n_regions < drc_pkg::MAX_REGIONS) begin
      regions[n_regions] = r;
      n_regions++;
      return;
    end
    // table full: fold everything into one box
    m = bbox(regions[0], r);
    for (i = 1; i < n_regions; i++) m = bbox(m, regions[i]);
    regions[0] = m;
    n_regions = 1;
    n_collapses++;
  endfunction

  // works out the result beats one command beat causes
  function automatic void update_region_table(drc_pkg::in_t b);
    drc_pkg::out_t e;
    area_t r;
    int k;
    e = '0;
    if (b.func == drc_pkg::FUNC_INVALIDATE) begin
      r.x = b.rect_left;
      r.y = b.rect_top;
      r.w = b.rect_width;
      r.h = b.rect_height;
      merge_rect(r);
      e.entry_count = 4'(n_regions);
      e.last = 1'b1;
      region_beats_q.push_back(e);
    end else begin
      n_drains++;
      if (n_regions == 0) begin
        e.last = 1'b1;
        region_beats_q.push_back(e);
      end
      for (k = 0; k < n_regions; k++) begin
        e = '0;
        e.out_left = drc_pkg::COORD_W'(regions[k].x);
        e.out_top = drc_pkg::COORD_W'(regions[k].y);
        e.out_width = drc_pkg::COORD_W'(regions[k].w);
        e.out_height = drc_pkg::COORD_W'(regions[k].h);
        e.entry_valid = 1'b1;
        e.last = (k + 1 == n_regions);
        region_beats_q.push_back(e);
      end
      n_regions = 0;
    end
  endfunction

  function automatic drc_pkg::in_t rect_cmd(bit f, int l, int t, int w, int h);
    drc_pkg::in_t c;
    c.func = f;
    c.rect_left = 16'(l);
    c.rect_top = 16'(t);
    c.rect_width = 16'(w);
    c.rect_height = 16'(h);
    return c;
  endfunction

  function automatic drc_pkg::in_t random_cmd();
    drc_pkg::in_t c;
    int sel;
    sel = $urandom_range(0, 99);
    c.func = drc_pkg::FUNC_INVALIDATE;
    c.rect_left = 16'($urandom);
    c.rect_top = 16'($urandom);
    c.rect_width = 16'($urandom);
    c.rect_height = 16'($urandom);
    if (sel < 12) begin
      c.func = drc_pkg::FUNC_DRAIN;
    end else if (sel >= 22) begin
      // rectangles around the visible area, small enough to stay apart sometimes
      c.rect_left = 16'(int'($urandom_range(0, scr_w + 6)) - 3);
      c.rect_top = 16'(int'($urandom_range(0, scr_h + 6)) - 3);
      c.rect_width = 16'($urandom_range(1, scr_w / 4 + 3));
      c.rect_height = 16'($urandom_range(1, scr_h / 4 + 3));
    end
    return c;
  endfunction

  // driver: bursts of beats with random gaps, unless steady_send is set
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        update_region_table(in_data);
        n_cmds++;
      end
      if (!in_valid || in_ready) begin
        if (!steady_send && gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (rect_cmds_q.size() > 0) begin
          in_data <= rect_cmds_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 10);
            gap_left <= $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result beat against the oldest prediction
  always @(posedge clk) begin
    drc_pkg::out_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (region_beats_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("unexpected result beat: l=%0d t=%0d w=%0d h=%0d v=%0b n=%0d last=%0b",
                     out_data.out_left, out_data.out_top, out_data.out_width,
                     out_data.out_height, out_data.entry_valid, out_data.entry_count,
                     out_data.last);
        end else begin
          e = region_beats_q.pop_front();
          n_checked++;
          if (out_data.out_left !== e.out_left || out_data.out_top !== e.out_top ||
              out_data.out_width !== e.out_width || out_data.out_height !== e.out_height ||
              out_data.entry_valid !== e.entry_valid ||
              out_data.entry_count !== e.entry_count || out_data.last !== e.last) begin
            bad_beats++;
            if (bad_beats <= 10) begin
              $display("mismatch: exp l=%0d t=%0d w=%0d h=%0d v=%0b n=%0d last=%0b",
                       e.out_left, e.out_top, e.out_width, e.out_height, e.entry_valid,
                       e.entry_count, e.last);
              $display("          got l=%0d t=%0d w=%0d h=%0d v=%0b n=%0d last=%0b",
                       out_data.out_left, out_data.out_top, out_data.out_width,
                       out_data.out_height, out_data.entry_valid, out_data.entry_count,
                       out_data.last);
            end
          end
        end
      end
      recv_cyc <= recv_cyc + 1;
      out_ready <= steady_recv || ((recv_cyc % stall_period) < stall_on);
    end
  end

  task automatic write_reg(drc_pkg::cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= drc_pkg::COORD_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      drc_pkg::CFG_SCREEN_WIDTH: scr_w = val & 32'h7fff;
      drc_pkg::CFG_SCREEN_HEIGHT: scr_h = val & 32'h7fff;
      default: grow_cfg = val[0];
    endcase
  endtask

  task automatic wait_idle();
    while (rect_cmds_q.size() > 0 || in_valid || region_beats_q.size() > 0)
      @(negedge clk);
    // let the sequencer settle before touching registers
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(int w, int h, int grow, int n_items, bit calm_send, bit calm_recv);
    int p, i;
    write_reg(drc_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(drc_pkg::CFG_SCREEN_HEIGHT, h);
    write_reg(drc_pkg::CFG_DEBUG_EXPAND, grow);
    @(negedge clk);
    p = $urandom_range(2, 8);
    steady_send <= calm_send;
    steady_recv <= calm_recv;
    stall_period <= p;
    stall_on <= $urandom_range(1, p - 1);
    for (i = 0; i < n_items; i++) rect_cmds_q.push_back(random_cmd());
    n_phases++;
    wait_idle();
  endtask

  initial begin
    int i;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part with the reset settings
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_DRAIN, 0, 0, 0, 0));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, 5, 5, 0, 10));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, 5, 5, 10, -1));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, -32768, -32768, -32768, -32768));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, 32767, 32767, 32767, 32767));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, -10, -20, 30, 40));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, 300, 230, 100, 100));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_DRAIN, -1, -1, -1, -1));
    // last slot absorbs an earlier one and moves into its place
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, 5, 12, 6, 6));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, 100, 100, 4, 4));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, 20, 8, 4, 6));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, 10, 0, 10, 10));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_DRAIN, 0, 0, 0, 0));
    // fill the table, then overflow it
    for (i = 0; i < drc_pkg::MAX_REGIONS; i++)
      rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, 30 * i, 50, 10, 10));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_INVALIDATE, 0, 200, 5, 5));
    rect_cmds_q.push_back(rect_cmd(drc_pkg::FUNC_DRAIN, 0, 0, 0, 0));
    wait_idle();

    run_phase(64, 48, 1, 40, 1'b0, 1'b0);
    run_phase(32767, 32767, 0, 30, 1'b0, 1'b1);
    run_phase(1, 1, 1, 20, 1'b0, 1'b0);
    run_phase(0, 0, 0, 10, 1'b1, 1'b0);
    run_phase(200, 150, 0, 30, 1'b1, 1'b1);
    run_phase(320, 240, 1, 20, 1'b0, 1'b0);

    $display("covered %0d command beats (%0d drains, %0d full-table collapses) over %0d settings",
             n_cmds, n_drains, n_collapses, n_phases);
    $display("checked %0d result beats, %0d bad", n_checked, bad_beats);
    if (bad_beats == 0) begin
      $display("dirty_rect_coalescer verification clean");
    end else begin
      $display("dirty_rect_coalescer verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d result beats outstanding", region_beats_q.size());
    $display("dirty_rect_coalescer verification failed");
    $finish;
  end

endmodule
